// File: sv/igde_pkg.sv
// igde_pkg: shared constants and types of the gravity direction estimator
// used by the divider, the top level and the testbench; no dependencies

package igde_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = 32 + SLOT_W;
  localparam int CFG_IDX_W  = 8;

  localparam logic [63:0] ONE_Q30   = 64'd1073741824;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_NORM   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_X     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_Y     = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_Z     = 8'd5;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

// File: sv/igde_in_if.sv
// igde_in_if: accelerometer sample channel, valid/ready handshake
// depends on nothing

interface igde_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;
  logic signed [31:0] accel_z;

  modport source(output valid, accel_x, accel_y, accel_z, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, output ready);
endinterface

// File: sv/igde_out_if.sv
// igde_out_if: gravity estimate result channel, valid/ready handshake
// depends on nothing

interface igde_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gravity_x;
  logic signed [31:0] gravity_y;
  logic signed [31:0] gravity_z;
  logic               updated;
  logic [6:0]         samples_held;

  modport source(output valid, gravity_x, gravity_y, gravity_z, updated, samples_held,
                 input ready);
  modport sink(input valid, gravity_x, gravity_y, gravity_z, updated, samples_held,
               output ready);
endinterface

// File: sv/igde_cfg_if.sv
// igde_cfg_if: register write channel, valid/ready with index and data
// depends on nothing

interface igde_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/igde_ram.sv
// igde_ram: generic single write port, single read port ram, registered read
// depends on nothing

module igde_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/igde_div.sv
// igde_div: restoring divider, one quotient bit per cycle
// depends on igde_pkg for the request and response structs

module igde_div (
  input  logic                clk,
  input  logic                rst_n,
  input  igde_pkg::div_req_t  req,
  output igde_pkg::div_rsp_t  rsp
);

  logic [63:0] q_r;
  logic [32:0] rem_r;
  logic [32:0] den_r;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [33:0] rem2;
  logic        fits;

  assign rem2 = {rem_r, q_r[63]};
  assign fits = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r <= 33'(req.num >> req.steps);
        q_r   <= req.num << (7'd64 - {1'b0, req.steps});
        den_r <= req.den;
        cnt_r <= req.steps;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (fits) begin
          rem_r <= 33'(rem2 - {1'b0, den_r});
        end else begin
          rem_r <= rem2[32:0];
        end
        q_r   <= {q_r[62:0], fits};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule

// File: sv/imu_gravity_direction_estimator.sv
// imu_gravity_direction_estimator: windowed accelerometer mean, normalised and
// low-pass blended into a gravity unit vector
// depends on igde_pkg, the channel interfaces, igde_ram and igde_div
//
// in_ch takes one Q16.16 three-axis sample per item; out_ch gives one item per
// sample: the Q1.30 gravity vector, the updated flag and the samples held.
// cfg_ch writes registers by index (window, alpha, threshold, initial gravity);
// always ready; the user must write it only while idle; the block has no guard.
// The samples sit in a 64-entry ram. Each item first rewrites one slot, then
// reads back the held samples one per cycle to form the sums, divides each sum
// by the count in a shared one-bit-per-cycle divider, squares through a single
// 33x33 multiplier, and, when the threshold passes, normalises: one shift per
// cycle, a 32-step square root and three divisions; it then blends with the
// estimate and normalises the blend the same way. One item is in work at a
// time; in_ch is ready while idle.
// A finished item waits in the output register; the next sample is taken
// meanwhile, and its result waits until out_ch has taken the previous one.
// Synchronous reset clears the window, the estimate and the registers to their
// reset values; the ram needs no clearing since only written slots are read.

module imu_gravity_direction_estimator (
  input  logic             clk,
  input  logic             rst_n,
  igde_in_if.sink          in_ch,
  igde_out_if.source       out_ch,
  igde_cfg_if.sink         cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_MDIV, S_MAG, S_NSHIFT, S_NSQ, S_NSQRT, S_NDIV,
    S_SEED, S_BLEND, S_BCHK, S_OUT
  } state_t;

  state_t state_r;

  logic [6:0]         window_len_r;
  logic [16:0]        alpha_r;
  logic [30:0]        min_norm_r;
  logic signed [31:0] init_r [3];

  logic [igde_pkg::SLOT_W-1:0] slot_r;
  logic [6:0]                  held_r;
  logic [6:0]                  cnt_r;
  logic                        rdv_r;
  logic [1:0]                  ax_r;
  logic                        wait_r;
  logic                        phase_r;
  logic                        seeded_r;
  logic                        upd_r;

  logic signed [igde_pkg::SUM_W-1:0] sum_r [3];
  logic [31:0]        mean_mag_r [3];
  logic [63:0]        mag2_r;
  logic signed [63:0] prod_r;
  logic [63:0]        nmag_r [3];
  logic               nneg_r [3];
  logic [63:0]        ss_r;
  logic [63:0]        x_r;
  logic [63:0]        res_r;
  logic [63:0]        bit_r;
  logic signed [31:0] newg_r [3];
  logic signed [31:0] est_r [3];
  logic signed [63:0] blend_r [3];

  logic               out_valid_r;
  logic signed [31:0] out_g_r [3];
  logic               out_upd_r;
  logic [6:0]         out_held_r;

  logic [6:0]  w_clamp;
  logic [7:0]  held_inc;
  logic [6:0]  held_nxt;
  logic [16:0] alpha_sat;
  logic [16:0] beta;
  logic [63:0] mx;
  logic [63:0] trial;
  logic [31:0] qs;
  logic [1:0]  bi;

  logic [igde_pkg::SUM_W-1:0] sum_mag;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;

  logic                        ram_we;
  logic [igde_pkg::SLOT_W-1:0] ram_raddr;
  logic [95:0]                 ram_rdata;

  igde_pkg::div_req_t div_req;
  igde_pkg::div_rsp_t div_rsp;

  igde_ram #(.WIDTH(96), .DEPTH(igde_pkg::MAX_WINDOW)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata ({in_ch.accel_x, in_ch.accel_y, in_ch.accel_z}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  igde_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign ram_we       = in_ch.valid && in_ch.ready;
  assign ram_raddr    = slot_r - cnt_r[igde_pkg::SLOT_W-1:0] - igde_pkg::SLOT_W'(1);

  // magnitude of the sum, unsigned so that the most negative sum stays exact
  assign sum_mag = sum_r[ax_r][igde_pkg::SUM_W-1] ? igde_pkg::SUM_W'(-sum_r[ax_r]) :
                                                    igde_pkg::SUM_W'(sum_r[ax_r]);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.gravity_x    = out_g_r[0];
  assign out_ch.gravity_y    = out_g_r[1];
  assign out_ch.gravity_z    = out_g_r[2];
  assign out_ch.updated      = out_upd_r;
  assign out_ch.samples_held = out_held_r;

  always_comb begin
    if (window_len_r == 7'd0) begin
      w_clamp = 7'd1;
    end else if (window_len_r > 7'(igde_pkg::MAX_WINDOW)) begin
      w_clamp = 7'(igde_pkg::MAX_WINDOW);
    end else begin
      w_clamp = window_len_r;
    end
    held_inc  = {1'b0, held_r} + 8'd1;
    held_nxt  = (held_inc > {1'b0, w_clamp}) ? w_clamp : held_inc[6:0];
    alpha_sat = (alpha_r > igde_pkg::ALPHA_ONE) ? igde_pkg::ALPHA_ONE : alpha_r;
    beta      = igde_pkg::ALPHA_ONE - alpha_sat;
    mx        = nmag_r[0];
    if (nmag_r[1] > mx) mx = nmag_r[1];
    if (nmag_r[2] > mx) mx = nmag_r[2];
    trial = res_r + bit_r;
    qs    = (div_rsp.quo > igde_pkg::ONE_Q30) ? igde_pkg::ONE_Q30[31:0] : div_rsp.quo[31:0];
    bi    = 2'((cnt_r - 7'd1) >> 1);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MAG: begin
        if (cnt_r < 7'd3) begin
          mul_a = {1'b0, mean_mag_r[cnt_r[1:0]]};
        end else begin
          mul_a = {2'b0, min_norm_r};
        end
        mul_b = mul_a;
      end
      S_NSQ: begin
        if (cnt_r < 7'd3) begin
          mul_a = {2'b0, nmag_r[cnt_r[1:0]][30:0]};
        end
        mul_b = mul_a;
      end
      S_BLEND: begin
        if (cnt_r < 7'd6) begin
          if (!cnt_r[0]) begin
            mul_a = {16'b0, alpha_sat};
            mul_b = {newg_r[cnt_r[2:1]][31], newg_r[cnt_r[2:1]]};
          end else begin
            mul_a = {16'b0, beta};
            mul_b = {est_r[cnt_r[2:1]][31], est_r[cnt_r[2:1]]};
          end
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    div_req.steps = '0;
    case (state_r)
      S_MDIV: begin
        div_req.start = !wait_r;
        div_req.num   = 64'(sum_mag);
        div_req.den   = 33'(held_r);
        div_req.steps = 6'(igde_pkg::SUM_W);
      end
      S_NDIV: begin
        div_req.start = !wait_r;
        div_req.num   = {3'b0, nmag_r[ax_r][30:0], 30'b0} + {32'b0, res_r[32:1]};
        div_req.den   = res_r[32:0];
        div_req.steps = 6'd32;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      window_len_r <= 7'd10;
      alpha_r      <= 17'd6554;
      min_norm_r   <= 31'd6554;
      init_r[0]    <= 32'sd0;
      init_r[1]    <= 32'sd0;
      init_r[2]    <= -32'sd1073741824;
      slot_r       <= '0;
      held_r       <= '0;
      cnt_r        <= '0;
      rdv_r        <= 1'b0;
      ax_r         <= '0;
      wait_r       <= 1'b0;
      phase_r      <= 1'b0;
      seeded_r     <= 1'b0;
      upd_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        est_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          igde_pkg::CFG_WINDOW_LEN: window_len_r <= cfg_ch.data[6:0];
          igde_pkg::CFG_ALPHA:      alpha_r      <= cfg_ch.data[16:0];
          igde_pkg::CFG_MIN_NORM:   min_norm_r   <= cfg_ch.data[30:0];
          igde_pkg::CFG_INIT_X:     init_r[0]    <= cfg_ch.data;
          igde_pkg::CFG_INIT_Y:     init_r[1]    <= cfg_ch.data;
          igde_pkg::CFG_INIT_Z:     init_r[2]    <= cfg_ch.data;
          default: ;
        endcase
      end

      if (out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            slot_r  <= slot_r + igde_pkg::SLOT_W'(1);
            held_r  <= held_nxt;
            cnt_r   <= '0;
            rdv_r   <= 1'b0;
            upd_r   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              sum_r[i] <= '0;
            end
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          if (cnt_r < held_r) begin
            cnt_r <= cnt_r + 7'd1;
            rdv_r <= 1'b1;
          end else begin
            rdv_r <= 1'b0;
          end
          if (rdv_r) begin
            sum_r[0] <= sum_r[0] + igde_pkg::SUM_W'($signed(ram_rdata[95:64]));
            sum_r[1] <= sum_r[1] + igde_pkg::SUM_W'($signed(ram_rdata[63:32]));
            sum_r[2] <= sum_r[2] + igde_pkg::SUM_W'($signed(ram_rdata[31:0]));
          end
          if (cnt_r == held_r && !rdv_r) begin
            ax_r    <= '0;
            wait_r  <= 1'b0;
            state_r <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (div_rsp.done) begin
            wait_r            <= 1'b0;
            mean_mag_r[ax_r]  <= div_rsp.quo[31:0];
            nneg_r[ax_r]      <= sum_r[ax_r][igde_pkg::SUM_W-1];
            if (ax_r == 2'd2) begin
              cnt_r   <= '0;
              mag2_r  <= '0;
              state_r <= S_MAG;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        S_MAG: begin
          cnt_r  <= cnt_r + 7'd1;
          prod_r <= prod[63:0];
          if (cnt_r >= 7'd1 && cnt_r <= 7'd3) begin
            mag2_r <= mag2_r + prod_r;
          end
          if (cnt_r == 7'd4) begin
            if (mag2_r > prod_r) begin
              for (int i = 0; i < 3; i++) begin
                nmag_r[i] <= {32'b0, mean_mag_r[i]};
              end
              phase_r <= 1'b0;
              state_r <= S_NSHIFT;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_NSHIFT: begin
          if (mx[63:31] != '0) begin
            for (int i = 0; i < 3; i++) begin
              nmag_r[i] <= nmag_r[i] >> 1;
            end
          end else if (!mx[30]) begin
            for (int i = 0; i < 3; i++) begin
              nmag_r[i] <= nmag_r[i] << 1;
            end
          end else begin
            cnt_r   <= '0;
            ss_r    <= '0;
            state_r <= S_NSQ;
          end
        end
        S_NSQ: begin
          prod_r <= prod[63:0];
          if (cnt_r >= 7'd1) begin
            ss_r <= ss_r + prod_r;
          end
          if (cnt_r == 7'd3) begin
            x_r     <= ss_r + prod_r;
            res_r   <= '0;
            bit_r   <= 64'h4000_0000_0000_0000;
            cnt_r   <= '0;
            state_r <= S_NSQRT;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        S_NSQRT: begin
          if (x_r >= trial) begin
            x_r   <= x_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd31) begin
            ax_r    <= '0;
            wait_r  <= 1'b0;
            state_r <= S_NDIV;
          end
        end
        S_NDIV: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (div_rsp.done) begin
            wait_r <= 1'b0;
            if (!phase_r) begin
              newg_r[ax_r] <= nneg_r[ax_r] ? $signed(qs) : -$signed(qs);
            end else begin
              est_r[ax_r] <= nneg_r[ax_r] ? -$signed(qs) : $signed(qs);
            end
            if (ax_r == 2'd2) begin
              if (!phase_r) begin
                state_r <= S_SEED;
              end else begin
                upd_r   <= 1'b1;
                state_r <= S_OUT;
              end
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        S_SEED: begin
          if (!seeded_r) begin
            for (int i = 0; i < 3; i++) begin
              est_r[i] <= init_r[i];
            end
            seeded_r <= 1'b1;
          end
          for (int i = 0; i < 3; i++) begin
            blend_r[i] <= '0;
          end
          cnt_r   <= '0;
          state_r <= S_BLEND;
        end
        S_BLEND: begin
          cnt_r  <= cnt_r + 7'd1;
          prod_r <= prod[63:0];
          if (cnt_r >= 7'd1) begin
            blend_r[bi] <= blend_r[bi] + prod_r;
          end
          if (cnt_r == 7'd6) begin
            state_r <= S_BCHK;
          end
        end
        S_BCHK: begin
          if (blend_r[0] == '0 && blend_r[1] == '0 && blend_r[2] == '0) begin
            state_r <= S_OUT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              nmag_r[i] <= blend_r[i][63] ? 64'(-blend_r[i]) : 64'(blend_r[i]);
              nneg_r[i] <= blend_r[i][63];
            end
            phase_r <= 1'b1;
            state_r <= S_NSHIFT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            for (int i = 0; i < 3; i++) begin
              out_g_r[i] <= seeded_r ? est_r[i] : init_r[i];
            end
            out_upd_r   <= upd_r;
            out_held_r  <= held_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: verif/igde_gravity_checker.sv
// igde_gravity_checker: watches the sample, result and register channels of the
// gravity direction estimator, predicts each result and compares it
// depends on igde_pkg and the igde_in_if, igde_out_if and igde_cfg_if interfaces
`timescale 1ns / 1ps

module igde_gravity_checker (
  input  logic clk,
  input  logic rst_n,
  igde_in_if   in_ch,
  igde_out_if  out_ch,
  igde_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);
  import igde_pkg::*;

  typedef logic signed [63:0] vec3_t [3];

  typedef struct {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
    logic               upd;
    logic [6:0]         held;
  } gravity_t;

  gravity_t expected_q[$];

  logic signed [31:0] win_x [MAX_WINDOW];
  logic signed [31:0] win_y [MAX_WINDOW];
  logic signed [31:0] win_z [MAX_WINDOW];
  int unsigned        held_n, slot;
  logic signed [63:0] grav_x, grav_y, grav_z;
  bit                 primed;

  logic [6:0]         r_window;
  logic [16:0]        r_alpha;
  logic [30:0]        r_min_norm;
  logic [31:0]        r_init_x, r_init_y, r_init_z;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit to_unit(input vec3_t v, output vec3_t u);
    logic [63:0] mag [3];
    logic [63:0] m, ss, n, q;
    m = 0;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return 0;
    while (m >= (64'd1 << 31)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) ss = ss + mag[i] * mag[i];
    n = int_sqrt(ss);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 30) + (n >> 1)) / n;
      if (q > ONE_Q30) q = ONE_Q30;
      u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1;
  endfunction

  function automatic gravity_t predict_gravity(logic signed [31:0] ax,
                                               logic signed [31:0] ay,
                                               logic signed [31:0] az);
    gravity_t           g;
    int unsigned        w, idx;
    logic signed [63:0] sx, sy, sz, a;
    vec3_t              mean, fresh, blend, res;
    logic [63:0]        mag2, thr, mm;
    bit                 upd;
    w = r_window;
    if (w < 1) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    win_x[slot] = ax;
    win_y[slot] = ay;
    win_z[slot] = az;
    slot = (slot + 1) % MAX_WINDOW;
    held_n = held_n + 1;
    if (held_n > w) held_n = w;
    sx = 0;
    sy = 0;
    sz = 0;
    for (int unsigned k = 1; k <= held_n; k++) begin
      idx = (slot + MAX_WINDOW - k) % MAX_WINDOW;
      sx = sx + win_x[idx];
      sy = sy + win_y[idx];
      sz = sz + win_z[idx];
    end
    mean[0] = sx / $signed(64'(held_n));
    mean[1] = sy / $signed(64'(held_n));
    mean[2] = sz / $signed(64'(held_n));
    mag2 = 0;
    for (int i = 0; i < 3; i++) begin
      mm = mean[i] < 0 ? 64'(-mean[i]) : 64'(mean[i]);
      mag2 = mag2 + mm * mm;
    end
    thr = 64'(r_min_norm) * 64'(r_min_norm);
    upd = 0;
    if (mag2 > thr && to_unit(mean, fresh)) begin
      if (!primed) begin
        grav_x = $signed(r_init_x);
        grav_y = $signed(r_init_y);
        grav_z = $signed(r_init_z);
        primed = 1;
      end
      a = r_alpha > ALPHA_ONE ? 64'(ALPHA_ONE) : 64'(r_alpha);
      blend[0] = a * -fresh[0] + (64'(ALPHA_ONE) - a) * grav_x;
      blend[1] = a * -fresh[1] + (64'(ALPHA_ONE) - a) * grav_y;
      blend[2] = a * -fresh[2] + (64'(ALPHA_ONE) - a) * grav_z;
      if (to_unit(blend, res)) begin
        grav_x = res[0];
        grav_y = res[1];
        grav_z = res[2];
        upd = 1;
      end
    end
    if (primed) begin
      g.gx = grav_x[31:0];
      g.gy = grav_y[31:0];
      g.gz = grav_z[31:0];
    end else begin
      g.gx = r_init_x;
      g.gy = r_init_y;
      g.gz = r_init_z;
    end
    g.upd = upd;
    g.held = held_n[6:0];
    return g;
  endfunction

  always @(posedge clk) begin
    gravity_t e;
    if (!rst_n) begin
      expected_q.delete();
      held_n = 0;
      slot = 0;
      grav_x = 0;
      grav_y = 0;
      grav_z = 0;
      primed = 0;
      r_window = 7'd10;
      r_alpha = 17'd6554;
      r_min_norm = 31'd6554;
      r_init_x = 32'h0;
      r_init_y = 32'h0;
      r_init_z = 32'hC000_0000;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_WINDOW_LEN: r_window = cfg_ch.data[6:0];
          CFG_ALPHA:      r_alpha = cfg_ch.data[16:0];
          CFG_MIN_NORM:   r_min_norm = cfg_ch.data[30:0];
          CFG_INIT_X:     r_init_x = cfg_ch.data;
          CFG_INIT_Y:     r_init_y = cfg_ch.data;
          CFG_INIT_Z:     r_init_z = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_q = {expected_q,
                      predict_gravity(in_ch.accel_x, in_ch.accel_y, in_ch.accel_z)};
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item gx=%h gy=%h gz=%h", $time,
                   out_ch.gravity_x, out_ch.gravity_y, out_ch.gravity_z);
          fail_count++;
        end else begin
          e = expected_q[0];
          expected_q.delete(0);
          if (out_ch.gravity_x !== e.gx) begin
            $display("%0t: gravity_x expected %h actual %h", $time, e.gx, out_ch.gravity_x);
            fail_count++;
          end
          if (out_ch.gravity_y !== e.gy) begin
            $display("%0t: gravity_y expected %h actual %h", $time, e.gy, out_ch.gravity_y);
            fail_count++;
          end
          if (out_ch.gravity_z !== e.gz) begin
            $display("%0t: gravity_z expected %h actual %h", $time, e.gz, out_ch.gravity_z);
            fail_count++;
          end
          if (out_ch.updated !== e.upd) begin
            $display("%0t: updated expected %b actual %b", $time, e.upd, out_ch.updated);
            fail_count++;
          end
          if (out_ch.samples_held !== e.held) begin
            $display("%0t: samples_held expected %0d actual %0d", $time, e.held,
                     out_ch.samples_held);
            fail_count++;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end
endmodule

// File: verif/imu_gravity_direction_estimator_tb.sv
// imu_gravity_direction_estimator_tb: drives samples and register writes into the
// estimator with random gaps and result stalls, and gives the verdict
// depends on igde_pkg, the channel interfaces, the estimator and igde_gravity_checker
`timescale 1ns / 1ps

module imu_gravity_direction_estimator_tb;
  import igde_pkg::*;

  localparam int G_Q16 = 642252;
  localparam longint CYCLE_LIMIT = 6000000;

  logic clk;
  logic rst_n;
  int   fail_count, pending;
  int   burst_left;
  bit   hold_req, hold_done;
  longint cycles;

  igde_in_if  in_if ();
  igde_out_if out_if ();
  igde_cfg_if cfg_if ();

  imu_gravity_direction_estimator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_ch(cfg_if.sink)
  );

  igde_gravity_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if), .cfg_ch(cfg_if),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side: stall pattern changes every segment, one long hold on request
  initial begin
    int mode, seg;
    out_if.ready = 0;
    mode = 0;
    seg = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_if.ready <= 0;
        repeat (3000) @(negedge clk);
        hold_done = 1;
      end else begin
        if (seg == 0) begin
          mode = $urandom_range(0, 3);
          seg = $urandom_range(16, 400);
        end
        seg--;
        case (mode)
          0: out_if.ready <= 1;
          1: out_if.ready <= $urandom_range(0, 1);
          2: out_if.ready <= ($urandom_range(0, 9) == 0);
          default: out_if.ready <= ($urandom_range(0, 5) != 0);
        endcase
      end
    end
  end

  task automatic put_sample(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 600);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_if.valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1;
    in_if.accel_x <= x;
    in_if.accel_y <= y;
    in_if.accel_z <= z;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 0;
  endtask

  function automatic logic [31:0] axis_value(int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 140000) - 70000;
      default: return $urandom_range(0, 100000) - 50000;
    endcase
  endfunction

  task automatic random_sample();
    int sel, dom;
    logic [31:0] v [3];
    sel = $urandom_range(0, 9);
    dom = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) v[i] = axis_value(sel == 0 ? 0 : (sel == 1 ? 1 : 2));
    if (sel > 1)
      v[dom] = v[dom] + ($urandom_range(0, 1) ? G_Q16 : -G_Q16);
    put_sample(v[0], v[1], v[2]);
  endtask

  initial begin
    logic [31:0] w, a, mn;
    rst_n = 0;
    hold_req = 0;
    hold_done = 0;
    burst_left = 0;
    in_if.valid = 0;
    in_if.accel_x = 0;
    in_if.accel_y = 0;
    in_if.accel_z = 0;
    cfg_if.valid = 0;
    cfg_if.index = CFG_WINDOW_LEN;
    cfg_if.data = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // not yet seeded: outputs follow the initial gravity as written
    put_sample(0, 0, 0);
    wait_idle();
    write_reg(CFG_MIN_NORM, 32'h7FFF_FFFF);
    write_reg(CFG_INIT_X, 32'h7FFF_FFFF);
    write_reg(CFG_INIT_Y, 32'h8000_0000);
    write_reg(CFG_INIT_Z, 32'h4000_0000);
    put_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    put_sample(32'h8000_0000, 32'h7FFF_FFFF, 0);
    wait_idle();

    // zero blend on the first update
    write_reg(CFG_INIT_X, 0);
    write_reg(CFG_INIT_Y, 0);
    write_reg(CFG_INIT_Z, 0);
    write_reg(CFG_ALPHA, 0);
    write_reg(CFG_MIN_NORM, 0);
    write_reg(CFG_WINDOW_LEN, 0);
    put_sample(0, 0, G_Q16);
    put_sample(0, 0, 0);
    wait_idle();

    write_reg(CFG_ALPHA, 131071);
    write_reg(CFG_WINDOW_LEN, 127);
    put_sample(1, 0, 0);
    put_sample(0, 32'hFFFF_FFFF, 0);
    put_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    for (int i = 0; i < 70; i++) random_sample();
    wait_idle();

    // window shrunk while full
    write_reg(CFG_WINDOW_LEN, 3);
    write_reg(CFG_ALPHA, 65536);
    write_reg(CFG_MIN_NORM, 6554);
    put_sample(0, G_Q16, 0);
    put_sample(0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 5))
        0: w = 0;
        1: w = 1;
        2: w = 64;
        3: w = 127;
        default: w = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 5))
        0: a = 0;
        1: a = 65536;
        2: a = 131071;
        default: a = $urandom_range(1, 65535);
      endcase
      case ($urandom_range(0, 5))
        0: mn = 0;
        1: mn = 32'h7FFF_FFFF;
        2: mn = $urandom() & 32'h7FFF_FFFF;
        default: mn = $urandom_range(0, 700000);
      endcase
      write_reg(CFG_WINDOW_LEN, w);
      write_reg(CFG_ALPHA, a);
      write_reg(CFG_MIN_NORM, mn);
      write_reg(CFG_INIT_X, $urandom());
      write_reg(CFG_INIT_Y, $urandom());
      write_reg(CFG_INIT_Z, $urandom());
      if (ph == 2) hold_req = 1;
      for (int i = 0; i < 140; i++) random_sample();
      wait_idle();
    end

    repeat (600) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
